@@ src/dhcplt_pkg.sv @@
// Shared types and codes for the DHCP relay lease table.
// Used by dhcplt_cell and dhcp_relay_lease_table; depends on nothing.
`default_nettype none
package dhcplt_pkg;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_RENEW     = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_NOTHING   = 3'd5;

    // Configuration register indexes.
    localparam logic REG_LOCAL_LEASE  = 1'b0;
    localparam logic REG_MISSED_LIMIT = 1'b1;

    // Entry states.
    localparam logic [1:0] ENT_UNUSED    = 2'd0;
    localparam logic [1:0] ENT_REQUESTED = 2'd1;
    localparam logic [1:0] ENT_GRANTED   = 2'd2;

    // Aging events raised by a cell on a tick.
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_REMOVE = 2'd1;
    localparam logic [1:0] EV_RENEW  = 2'd2;

    // Command broadcast to every cell.
    typedef struct packed {
        logic [1:0]  op;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [31:0] lease;
        logic [31:0] local_lease_time;
        logic [3:0]  missed_limit;
    } cell_cmd_t;

    // What one cell shows to the walker.
    typedef struct packed {
        logic        used;
        logic        granted;
        logic        hit;
        logic [1:0]  event_code;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [31:0] offer;
    } cell_view_t;

endpackage
`default_nettype wire

@@ src/dhcplt_cell.sv @@
// One lease entry of the DHCP relay lease table with its own update logic.
// Depends on dhcplt_pkg.
`default_nettype none
module dhcplt_cell
    import dhcplt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       sel,
    input  wire logic       wr,
    input  wire cell_cmd_t  cmd,
    output cell_view_t      view
);

    logic [1:0]  state_reg, state_next;
    logic [47:0] mac_reg, mac_next;
    logic [31:0] ip_reg, ip_next;
    logic [31:0] expiry_reg, expiry_next;
    logic [31:0] remain_reg, remain_next;
    logic [3:0]  missed_reg, missed_next;

    logic        granted;
    logic        hit;
    logic        exp_ge2;
    logic [3:0]  missed_inc;
    logic        remove;
    logic        renew;

    // Tick aging decisions for this entry.
    assign granted    = (state_reg == ENT_GRANTED);
    assign hit        = (mac_reg == cmd.mac);
    assign exp_ge2    = (expiry_reg >= 32'd2);
    assign missed_inc = missed_reg + 4'd1;
    assign remove     = !exp_ge2 && (missed_inc >= cmd.missed_limit);
    assign renew      = !remove && (remain_reg < 32'd2);

    // View presented to the walker.
    always_comb begin
        view.used       = (state_reg != ENT_UNUSED);
        view.granted    = granted;
        view.hit        = hit;
        view.event_code = !granted ? EV_NONE : remove ? EV_REMOVE : renew ? EV_RENEW : EV_NONE;
        view.mac        = mac_reg;
        view.ip         = ip_reg;
        view.offer      = (expiry_reg < cmd.local_lease_time) ? expiry_reg
                                                               : cmd.local_lease_time;
    end

    // Next entry contents.
    always_comb begin
        state_next  = state_reg;
        mac_next    = mac_reg;
        ip_next     = ip_reg;
        expiry_next = expiry_reg;
        remain_next = remain_reg;
        missed_next = missed_reg;
        if (wr) begin
            state_next  = ENT_GRANTED;
            mac_next    = cmd.mac;
            ip_next     = cmd.ip;
            expiry_next = cmd.local_lease_time;
            remain_next = cmd.lease;
            missed_next = 4'd0;
        end else if (sel && granted) begin
            case (cmd.op)
                OP_DELETE: begin
                    if (hit) begin
                        state_next = ENT_UNUSED;
                    end
                end
                OP_TICK: begin
                    if (!exp_ge2) begin
                        missed_next = missed_inc;
                    end
                    if (remove) begin
                        state_next = ENT_UNUSED;
                    end else begin
                        expiry_next = exp_ge2 ? expiry_reg - 32'd1 : cmd.local_lease_time;
                        if (renew) begin
                            state_next = ENT_REQUESTED;
                        end else begin
                            remain_next = remain_reg - 32'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ENT_UNUSED;
        end else begin
            state_reg <= state_next;
        end
        mac_reg    <= mac_next;
        ip_reg     <= ip_next;
        expiry_reg <= expiry_next;
        remain_reg <= remain_next;
        missed_reg <= missed_next;
    end

endmodule
`default_nettype wire

@@ src/dhcp_relay_lease_table.sv @@
// Top level of the DHCP relay lease table: a row of entry cells and the walker.
// Depends on dhcplt_pkg and dhcplt_cell.
`default_nettype none
// Each transaction is handled by a walk over the row of entry cells, one cell per
// cycle from slot 0 upward, stalled while a result waits unread in the output
// register; a record then writes the chosen slot, if any, in a write state after the walk.
// Lookups and ticks end early at the first entry that answers. One operation is in
// work at a time, and a new one is accepted while the previous result still waits
// in the output register. Configuration writes take effect at once.
module dhcp_relay_lease_table
    import dhcplt_pkg::*;
#(
    parameter int ENTRIES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [47:0] s_client_mac,
    input  wire logic [31:0] s_client_ip,
    input  wire logic [31:0] s_server_lease,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [2:0]       m_slot,
    output logic [47:0]      m_found_mac,
    output logic [31:0]      m_found_ip,
    output logic [31:0]      m_offered_lease
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [31:0]   llt_reg;
    logic [3:0]    limit_reg;
    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic          free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [1:0]    op_reg;
    logic [47:0]   mac_reg;
    logic [31:0]   ip_reg;
    logic [31:0]   lease_reg;
    logic          mv_reg, mv_next;
    logic [2:0]    st_reg, st_next;
    logic [2:0]    slot_reg, slot_next;
    logic [47:0]   fmac_reg, fmac_next;
    logic [31:0]   fip_reg, fip_next;
    logic [31:0]   offer_reg, offer_next;

    cell_cmd_t     cmd;
    cell_view_t    views [ENTRIES];
    cell_view_t    cur;
    logic          out_free;
    logic          step_en;
    logic          accept;
    logic [IW-1:0] wr_idx;
    logic          do_write;

    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign step_en  = (state_reg == S_WALK) && out_free;
    assign wr_idx   = hit_reg ? hit_idx_reg : free_idx_reg;
    assign do_write = (state_reg == S_WRITE) && out_free && (hit_reg || free_reg);
    assign cur      = views[idx_reg];

    always_comb begin
        cmd.op               = op_reg;
        cmd.mac              = mac_reg;
        cmd.ip               = ip_reg;
        cmd.lease            = lease_reg;
        cmd.local_lease_time = llt_reg;
        cmd.missed_limit     = limit_reg;
    end

    // Row of entry cells; the walker selects one cell per cycle while the output register is free.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        dhcplt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .sel     (step_en && (idx_reg == IW'(g))),
            .wr      (do_write && (wr_idx == IW'(g))),
            .cmd     (cmd),
            .view    (views[g])
        );
    end

    // Walk sequencer and result formation.
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        mv_next       = mv_reg && !m_ready;
        st_next       = st_reg;
        slot_next     = slot_reg;
        fmac_next     = fmac_reg;
        fip_next      = fip_reg;
        offer_next    = offer_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_WALK;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                end
            end
            S_WALK: begin
                if (step_en) begin
                    idx_next   = idx_reg + IW'(1);
                    st_next    = ST_NOTHING;
                    slot_next  = 3'd0;
                    fmac_next  = '0;
                    fip_next   = '0;
                    offer_next = '0;
                    case (op_reg)
                        OP_RECORD: begin
                            if (cur.used && cur.hit) begin
                                hit_next     = 1'b1;
                                hit_idx_next = idx_reg;
                            end
                            if (!cur.used) begin
                                free_next     = 1'b1;
                                free_idx_next = idx_reg;
                            end
                            if (idx_reg == LAST) begin
                                state_next = S_WRITE;
                            end
                        end
                        OP_DELETE: begin
                            if (cur.granted && cur.hit && !hit_reg) begin
                                hit_next     = 1'b1;
                                hit_idx_next = idx_reg;
                            end
                            if (idx_reg == LAST) begin
                                state_next = S_IDLE;
                                mv_next    = 1'b1;
                                if (hit_next) begin
                                    st_next   = ST_DONE;
                                    slot_next = 3'(hit_idx_next);
                                end else begin
                                    st_next = ST_NOT_FOUND;
                                end
                            end
                        end
                        OP_LOOKUP: begin
                            if (cur.used && cur.hit) begin
                                state_next = S_IDLE;
                                mv_next    = 1'b1;
                                st_next    = ST_DONE;
                                slot_next  = 3'(idx_reg);
                                fmac_next  = cur.mac;
                                fip_next   = cur.ip;
                                offer_next = cur.offer;
                            end else if (idx_reg == LAST) begin
                                state_next = S_IDLE;
                                mv_next    = 1'b1;
                                st_next    = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (cur.event_code != EV_NONE) begin
                                state_next = S_IDLE;
                                mv_next    = 1'b1;
                                st_next    = (cur.event_code == EV_REMOVE) ? ST_REMOVED
                                                                           : ST_RENEW;
                                slot_next  = 3'(idx_reg);
                                fmac_next  = cur.mac;
                                fip_next   = cur.ip;
                            end else if (idx_reg == LAST) begin
                                state_next = S_IDLE;
                                mv_next    = 1'b1;
                                st_next    = ST_NOTHING;
                            end
                        end
                    endcase
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                    mv_next    = 1'b1;
                    fmac_next  = '0;
                    fip_next   = '0;
                    offer_next = '0;
                    if (hit_reg || free_reg) begin
                        st_next   = ST_DONE;
                        slot_next = 3'(wr_idx);
                    end else begin
                        st_next   = ST_FULL;
                        slot_next = 3'd0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
            llt_reg   <= 32'd3600;
            limit_reg <= 4'd5;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_LOCAL_LEASE: begin
                        llt_reg <= cfg_wdata;
                    end
                    REG_MISSED_LIMIT: begin
                        limit_reg <= cfg_wdata[3:0];
                    end
                endcase
            end
        end
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        st_reg       <= st_next;
        slot_reg     <= slot_next;
        fmac_reg     <= fmac_next;
        fip_reg      <= fip_next;
        offer_reg    <= offer_next;
        // Capture the transaction payload on accept.
        if (accept) begin
            op_reg    <= s_operation;
            mac_reg   <= s_client_mac;
            ip_reg    <= s_client_ip;
            lease_reg <= s_server_lease;
        end
    end

    assign m_valid         = mv_reg;
    assign m_status        = st_reg;
    assign m_slot          = slot_reg;
    assign m_found_mac     = fmac_reg;
    assign m_found_ip      = fip_reg;
    assign m_offered_lease = offer_reg;

endmodule
`default_nettype wire
